/* hdl/slfd_pkg.sv */
`default_nettype none

package slfd_pkg;

   // image and frame geometry
   localparam int IMAGE_BYTES = 32;
   localparam int FRAME_BYTES = 25;
   localparam int IMG_AW      = $clog2(IMAGE_BYTES);
   localparam int FRM_CW      = $clog2(FRAME_BYTES + 1);

   // special item addresses
   localparam logic [9:0] ADDR_FILL      = 10'd512;
   localparam logic [9:0] ADDR_BACKLIGHT = 10'd513;

   // register indexes on the csr port
   localparam logic REG_MODE = 1'b0;
   localparam logic REG_BASE = 1'b1;

   // register reset values
   localparam logic [3:0] MODE_RESET = 4'd5;
   localparam logic [7:0] BASE_RESET = 8'd245;

   // glyph index shown for out-of-range values
   localparam int GLYPH_BLANK = 50;

   localparam logic [7:0] GLYPH_TABLE [51] = '{
      8'hD7, 8'h06, 8'hE3, 8'hA7, 8'h36, 8'hB5, 8'hF5, 8'h07, 8'hF7, 8'hB7,
      8'hDF, 8'h0E, 8'hEB, 8'hAF, 8'h3E, 8'hBD, 8'hFD, 8'h0F, 8'hFF, 8'hBF,
      8'h77, 8'hF4, 8'hD1, 8'hE6, 8'hF1, 8'h71, 8'hB7, 8'h76, 8'h50, 8'h86,
      8'h00, 8'hD0, 8'h57, 8'h64, 8'hE4, 8'h73, 8'h37, 8'h60, 8'hB5, 8'hF0,
      8'hD6, 8'h00, 8'h00, 8'h00, 8'h36, 8'h00, 8'h01, 8'h20, 8'h80, 8'h33,
      8'h00
   };

   // operations passed from front to back
   typedef enum logic [2:0] {
      OP_NONE,
      OP_RMW,
      OP_FILL,
      OP_BACKLIGHT,
      OP_FLUSH
   } op_type;

   // one read-modify-write of an image byte: new = (old & keep) | set
   typedef struct packed {
      logic              en;
      logic [IMG_AW-1:0] idx;
      logic [7:0]        keep;
      logic [7:0]        set;
   } step_type;

   typedef struct packed {
      op_type        op;
      step_type [1:0] step;
      logic          flag;
   } cmd_type;

   // back end sequencer states
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_RD,
      BK_WR,
      BK_HEAD,
      BK_BODY_RD,
      BK_BODY_OUT
   } bk_state_type;

   function automatic logic [7:0] glyph_of(input logic signed [7:0] v);
      logic [7:0] g;
      if (v < 8'sd0 || v > 8'sd50) begin
         g = GLYPH_TABLE[GLYPH_BLANK];
      end else begin
         g = GLYPH_TABLE[v[5:0]];
      end
      return g;
   endfunction

endpackage

`default_nettype wire

/* hdl/slfd_front.sv */
`default_nettype none

module slfd_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_kind,
   input  wire logic [9:0]             req_address,
   input  wire logic signed [7:0]      req_value,
   input  wire logic [7:0]             digit_base,
   output logic                        cmd_valid,
   input  wire logic                   cmd_ready,
   output slfd_pkg::cmd_type           cmd
);

   logic              front_valid_ff, front_valid_in;
   slfd_pkg::cmd_type cmd_ff, cmd_in;
   logic              req_accept;
   logic [7:0]        addr8;
   logic [7:0]        slot;
   logic              dp;
   logic signed [7:0] gv;
   logic [7:0]        g;
   logic [7:0]        g_raw;
   logic [7:0]        bit_mask;
   logic              positive;

   function automatic slfd_pkg::step_type mk_step(input logic [4:0] b, input logic [7:0] keep,
                                                  input logic [7:0] set);
      slfd_pkg::step_type s;
      s.en   = (int'(b) < slfd_pkg::IMAGE_BYTES);
      s.idx  = slfd_pkg::IMG_AW'(b);
      s.keep = keep;
      s.set  = set;
      return s;
   endfunction

   assign req_accept = req_valid && req_ready;
   assign req_ready  = !front_valid_ff || cmd_ready;
   assign cmd_valid  = front_valid_ff;
   assign cmd        = cmd_ff;

   // glyph and decimal point for digit writes
   always_comb begin
      addr8    = req_address[7:0];
      slot     = addr8 - digit_base;
      dp       = (req_value >= 8'sd10) && (req_value <= 8'sd19);
      gv       = dp ? (req_value - 8'sd10) : req_value;
      g        = slfd_pkg::glyph_of(gv);
      // small digits take the value as given, no decimal point offset
      g_raw    = slfd_pkg::glyph_of(req_value);
      bit_mask = 8'(1) << addr8[2:0];
      positive = !req_value[7] && (req_value != 8'sd0);
   end

   // classify the item
   always_comb begin
      cmd_in         = '0;
      cmd_in.op      = slfd_pkg::OP_NONE;
      if (req_kind) begin
         cmd_in.op = slfd_pkg::OP_FLUSH;
      end else if (req_address[9:8] == 2'b00) begin
         if (addr8 < digit_base) begin
            cmd_in.op      = slfd_pkg::OP_RMW;
            cmd_in.step[0] = mk_step(addr8[7:3], ~bit_mask, positive ? bit_mask : 8'h00);
         end else begin
            cmd_in.op = slfd_pkg::OP_RMW;
            case (slot)
               8'd0, 8'd1, 8'd2, 8'd3: begin
                  // main digit: decimal point in next byte, glyph nibbles swapped
                  cmd_in.step[0] = mk_step(5'(slot) + 5'd2, 8'h7F, {dp, 7'b0});
                  cmd_in.step[1] = mk_step(5'(slot) + 5'd1, 8'h80, {g[3:0], g[7:4]});
               end
               8'd4: begin
                  cmd_in.step[0] = mk_step(5'd10, 8'h00, g_raw);
               end
               8'd5: begin
                  cmd_in.step[0] = mk_step(5'd9, 8'h00, g_raw);
               end
               8'd6: begin
                  cmd_in.step[0] = mk_step(5'd8, 8'hF0, {4'b0, g_raw[7:4]});
                  cmd_in.step[1] = mk_step(5'd7, 8'h0F, {g_raw[3:0], 4'b0});
               end
               8'd7: begin
                  cmd_in.step[0] = mk_step(5'd7, 8'hF0, {4'b0, g_raw[7:4]});
                  cmd_in.step[1] = mk_step(5'd6, 8'h0F, {g_raw[3:0], 4'b0});
               end
               default: begin
                  cmd_in.op = slfd_pkg::OP_NONE;
               end
            endcase
         end
      end else if (req_address == slfd_pkg::ADDR_FILL) begin
         cmd_in.op   = slfd_pkg::OP_FILL;
         cmd_in.flag = (req_value != 8'sd0);
      end else if (req_address == slfd_pkg::ADDR_BACKLIGHT) begin
         cmd_in.op   = slfd_pkg::OP_BACKLIGHT;
         cmd_in.flag = req_value[0];
      end
   end

   // holding stage toward the queue
   always_comb begin
      front_valid_in = req_accept || (front_valid_ff && !cmd_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/slfd_queue.sv */
`default_nettype none

module slfd_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire slfd_pkg::cmd_type  in_cmd,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output slfd_pkg::cmd_type       out_cmd
);

   slfd_pkg::cmd_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_cmd   = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

`default_nettype wire

/* hdl/slfd_back.sv */
`default_nettype none

module slfd_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               cmd_valid,
   output logic                    cmd_ready,
   input  wire slfd_pkg::cmd_type  cmd,
   input  wire logic [3:0]         mode_code,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [7:0]              rsp_frame_byte,
   output logic                    rsp_is_header,
   output logic                    rsp_last,
   output logic                    rsp_backlight
);

   localparam int IB = slfd_pkg::IMAGE_BYTES;
   localparam int AW = slfd_pkg::IMG_AW;
   localparam int CW = slfd_pkg::FRM_CW;

   slfd_pkg::bk_state_type state_ff, state_in;
   slfd_pkg::cmd_type      cmd_ff, cmd_in;
   logic                   step_ff, step_in;
   logic [CW-1:0]          k_ff, k_in;
   logic                   dirty_ff, dirty_in;
   logic                   bl_ff, bl_in;
   logic                   fill_ff, fill_in;
   logic [IB-1:0]          valid_ff, valid_in;
   logic                   rvalid_ff, rvalid_in;
   logic [7:0]             mem [IB];
   logic [7:0]             rdata_ff;

   logic                   out_valid_ff, out_valid_in;
   logic [7:0]             out_byte_ff, out_byte_in;
   logic                   out_hdr_ff, out_hdr_in;
   logic                   out_last_ff, out_last_in;
   logic                   out_bl_ff, out_bl_in;

   logic                   pop;
   logic                   out_free;
   logic                   out_load;
   logic                   mem_re, mem_we;
   logic [AW-1:0]          rd_addr, wr_addr;
   logic [7:0]             wdata;
   logic [7:0]             old_byte;
   logic                   k_in_img;
   logic                   k_done;
   slfd_pkg::step_type     cur_step;

   assign rsp_valid      = out_valid_ff;
   assign rsp_frame_byte = out_byte_ff;
   assign rsp_is_header  = out_hdr_ff;
   assign rsp_last       = out_last_ff;
   assign rsp_backlight  = out_bl_ff;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign cur_step  = cmd_ff.step[step_ff];
   assign old_byte  = rvalid_ff ? rdata_ff : {8{fill_ff}};
   assign k_in_img  = (int'(k_ff) < IB);
   assign k_done    = (int'(k_ff) == slfd_pkg::FRAME_BYTES - 1);
   assign cmd_ready = (state_ff == slfd_pkg::BK_IDLE);
   assign pop       = cmd_valid && cmd_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         slfd_pkg::BK_IDLE: begin
            if (pop) begin
               case (cmd.op)
                  slfd_pkg::OP_RMW:   state_in = slfd_pkg::BK_RD;
                  slfd_pkg::OP_FILL:  state_in = slfd_pkg::BK_HEAD;
                  slfd_pkg::OP_FLUSH: state_in = dirty_ff ? slfd_pkg::BK_HEAD
                                                          : slfd_pkg::BK_IDLE;
                  default:            state_in = slfd_pkg::BK_IDLE;
               endcase
            end
         end
         slfd_pkg::BK_RD: begin
            if (cur_step.en) begin
               state_in = slfd_pkg::BK_WR;
            end else if (step_ff) begin
               state_in = slfd_pkg::BK_IDLE;
            end
         end
         slfd_pkg::BK_WR: begin
            state_in = step_ff ? slfd_pkg::BK_IDLE : slfd_pkg::BK_RD;
         end
         slfd_pkg::BK_HEAD: begin
            if (out_free) begin
               state_in = slfd_pkg::BK_BODY_RD;
            end
         end
         slfd_pkg::BK_BODY_RD: begin
            state_in = slfd_pkg::BK_BODY_OUT;
         end
         slfd_pkg::BK_BODY_OUT: begin
            if (out_free) begin
               state_in = k_done ? slfd_pkg::BK_IDLE : slfd_pkg::BK_BODY_RD;
            end
         end
         default: begin
            state_in = slfd_pkg::BK_IDLE;
         end
      endcase
   end

   // datapath controls per state
   always_comb begin
      cmd_in      = cmd_ff;
      step_in     = step_ff;
      k_in        = k_ff;
      dirty_in    = dirty_ff;
      bl_in       = bl_ff;
      fill_in     = fill_ff;
      valid_in    = valid_ff;
      rvalid_in   = rvalid_ff;
      mem_re      = 1'b0;
      mem_we      = 1'b0;
      rd_addr     = cur_step.idx;
      wr_addr     = cur_step.idx;
      wdata       = (old_byte & cur_step.keep) | cur_step.set;
      out_load    = 1'b0;
      out_byte_in = out_byte_ff;
      out_hdr_in  = out_hdr_ff;
      out_last_in = out_last_ff;
      out_bl_in   = out_bl_ff;
      case (state_ff)
         slfd_pkg::BK_IDLE: begin
            if (pop) begin
               cmd_in  = cmd;
               step_in = 1'b0;
               k_in    = '0;
               case (cmd.op)
                  slfd_pkg::OP_FLUSH: begin
                     dirty_in = 1'b0;
                  end
                  slfd_pkg::OP_FILL: begin
                     dirty_in = 1'b1;
                     fill_in  = cmd.flag;
                     valid_in = '0;
                  end
                  slfd_pkg::OP_BACKLIGHT: begin
                     dirty_in = 1'b1;
                     bl_in    = cmd.flag;
                  end
                  default: begin
                     dirty_in = 1'b1;
                  end
               endcase
            end
         end
         slfd_pkg::BK_RD: begin
            if (cur_step.en) begin
               mem_re    = 1'b1;
               rvalid_in = valid_ff[cur_step.idx];
            end else begin
               step_in = 1'b1;
            end
         end
         slfd_pkg::BK_WR: begin
            mem_we                = 1'b1;
            valid_in[cur_step.idx] = 1'b1;
            step_in               = 1'b1;
         end
         slfd_pkg::BK_HEAD: begin
            if (out_free) begin
               out_load    = 1'b1;
               out_byte_in = {4'b0, mode_code};
               out_hdr_in  = 1'b1;
               out_last_in = 1'b0;
               out_bl_in   = bl_ff;
            end
         end
         slfd_pkg::BK_BODY_RD: begin
            mem_re    = 1'b1;
            rd_addr   = AW'(k_ff);
            rvalid_in = valid_ff[AW'(k_ff)];
         end
         slfd_pkg::BK_BODY_OUT: begin
            if (out_free) begin
               out_load    = 1'b1;
               out_byte_in = k_in_img ? old_byte : 8'h00;
               out_hdr_in  = 1'b0;
               out_last_in = k_done;
               out_bl_in   = bl_ff;
               k_in        = CW'(k_ff + 1'b1);
            end
         end
         default: begin
            step_in = 1'b0;
         end
      endcase
      out_valid_in = out_load || (out_valid_ff && !rsp_ready);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= slfd_pkg::BK_IDLE;
         step_ff      <= 1'b0;
         k_ff         <= '0;
         dirty_ff     <= 1'b0;
         bl_ff        <= 1'b0;
         fill_ff      <= 1'b0;
         valid_ff     <= '0;
         rvalid_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         k_ff         <= k_in;
         dirty_ff     <= dirty_in;
         bl_ff        <= bl_in;
         fill_ff      <= fill_in;
         valid_ff     <= valid_in;
         rvalid_ff    <= rvalid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (out_load) begin
         out_byte_ff <= out_byte_in;
         out_hdr_ff  <= out_hdr_in;
         out_last_ff <= out_last_in;
         out_bl_ff   <= out_bl_in;
      end
   end

   // segment image memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* hdl/segment_lcd_frame_driver_unit.sv */
// a write item passes the front register and the queue, then the back end applies it
// a frame (header plus 25 image bytes) passes the back end sequencer's header state,
// then a read and an output state per byte, one image memory read per byte
// input transfers continue during a frame until the command queue and front register fill
// reset: synchronous; image reads blank through per-byte valid bits,
// registers return to mode 5 and digit base 245, no memory clearing pass
`default_nettype none

module segment_lcd_frame_driver_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_kind,
   input  wire logic [9:0]         req_address,
   input  wire logic signed [7:0]  req_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [7:0]              rsp_frame_byte,
   output logic                    rsp_is_header,
   output logic                    rsp_last,
   output logic                    rsp_backlight,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [2:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);

   logic [3:0]        mode_ff, mode_in;
   logic [7:0]        base_ff, base_in;
   logic              csr_write;
   logic              front_valid, front_ready;
   slfd_pkg::cmd_type front_cmd;
   logic              q_valid, q_ready;
   slfd_pkg::cmd_type q_cmd;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == slfd_pkg::REG_BASE) ? {24'b0, base_ff}
                                                            : {28'b0, mode_ff};

   always_comb begin
      mode_in = mode_ff;
      base_in = base_ff;
      if (csr_write) begin
         if (csr_paddr[2] == slfd_pkg::REG_MODE) begin
            mode_in = csr_pwdata[3:0];
         end else begin
            base_in = csr_pwdata[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= slfd_pkg::MODE_RESET;
         base_ff <= slfd_pkg::BASE_RESET;
      end else begin
         mode_ff <= mode_in;
         base_ff <= base_in;
      end
   end

   // classification stage
   slfd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_kind    (req_kind),
      .req_address (req_address),
      .req_value   (req_value),
      .digit_base  (base_ff),
      .cmd_valid   (front_valid),
      .cmd_ready   (front_ready),
      .cmd         (front_cmd)
   );

   // command queue
   slfd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_cmd    (front_cmd),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_cmd   (q_cmd)
   );

   // image keeper and frame sender
   slfd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (q_valid),
      .cmd_ready      (q_ready),
      .cmd            (q_cmd),
      .mode_code      (mode_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_is_header  (rsp_is_header),
      .rsp_last       (rsp_last),
      .rsp_backlight  (rsp_backlight)
   );

endmodule

`default_nettype wire

/* hdl/slfd_checker.sv */
`default_nettype none

module slfd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [7:0]  rsp_frame_byte,
   input wire logic        rsp_is_header,
   input wire logic        rsp_last,
   input wire logic        rsp_backlight,
   input wire logic        csr_pready
);

   // stalled result holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_byte)
         && $stable(rsp_is_header) && $stable(rsp_last) && $stable(rsp_backlight))
      else $error("stalled result changed");

   // header is never the final byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_is_header && rsp_last))
      else $error("header marked last");

   // a header transfer is followed by image bytes, not another header
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_is_header |=> !(rsp_valid && rsp_is_header))
      else $error("header repeated");

   // nothing pending right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // config port never waits
   assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("pready low");

endmodule

bind segment_lcd_frame_driver_unit slfd_checker u_slfd_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_frame_byte (rsp_frame_byte),
   .rsp_is_header  (rsp_is_header),
   .rsp_last       (rsp_last),
   .rsp_backlight  (rsp_backlight),
   .csr_pready     (csr_pready)
);

`default_nettype wire

/* sim/segment_lcd_frame_driver_unit_tb.sv */
`default_nettype none

module segment_lcd_frame_driver_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int QUIET_CYCLES = 40;
   localparam int HOLD_CYCLES  = 600;
   localparam int MAX_GAP      = 19;
   localparam int IMG_SIZE     = 32;
   localparam int FRAME_LEN    = 25;
   localparam int BLANK_GLYPH  = 50;

   // seven-segment patterns, index 50 is the blank glyph
   localparam logic [7:0] SEVEN_SEG [51] = '{
      8'hD7, 8'h06, 8'hE3, 8'hA7, 8'h36, 8'hB5, 8'hF5, 8'h07, 8'hF7, 8'hB7,
      8'hDF, 8'h0E, 8'hEB, 8'hAF, 8'h3E, 8'hBD, 8'hFD, 8'h0F, 8'hFF, 8'hBF,
      8'h77, 8'hF4, 8'hD1, 8'hE6, 8'hF1, 8'h71, 8'hB7, 8'h76, 8'h50, 8'h86,
      8'h00, 8'hD0, 8'h57, 8'h64, 8'hE4, 8'h73, 8'h37, 8'h60, 8'hB5, 8'hF0,
      8'hD6, 8'h00, 8'h00, 8'h00, 8'h36, 8'h00, 8'h01, 8'h20, 8'h80, 8'h33,
      8'h00
   };

   // item kinds
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   typedef struct {
      logic [7:0] data;
      logic       hdr;
      logic       lst;
      logic       bl;
   } lcd_out_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_kind = 1'b0;
   logic [9:0]         req_address = '0;
   logic signed [7:0]  req_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [7:0]         rsp_frame_byte;
   logic               rsp_is_header;
   logic               rsp_last;
   logic               rsp_backlight;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [2:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   // predicted display state
   logic [7:0]  lcd_image [IMG_SIZE];
   bit          image_dirty;
   bit          backlight_on;
   logic [3:0]  hdr_mode;
   logic [7:0]  slot_base;
   lcd_out_type frame_expect [$];

   // run bookkeeping
   int  error_count;
   int  items_sent;
   int  bytes_checked;
   int  frames_checked;
   int  reg_writes;
   int  cycle_count;
   int  hold_left;
   int  rx_stall;
   bit  gaps_on = 1'b1;
   lcd_out_type want;

   segment_lcd_frame_driver_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_address    (req_address),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_is_header  (rsp_is_header),
      .rsp_last       (rsp_last),
      .rsp_backlight  (rsp_backlight),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   // clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
         $display("** segment_lcd_frame_driver_unit: FAILED **");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // display state predictor
   // ------------------------------------------------------------------

   function automatic void lcd_clear_state();
      for (int i = 0; i < IMG_SIZE; i++) lcd_image[i] = 8'h00;
      image_dirty  = 1'b0;
      backlight_on = 1'b0;
      hdr_mode     = slfd_pkg::MODE_RESET;
      slot_base    = slfd_pkg::BASE_RESET;
   endfunction

   function automatic logic [7:0] glyph_for(int v);
      if (v < 0 || v > 50) return SEVEN_SEG[BLANK_GLYPH];
      return SEVEN_SEG[v];
   endfunction

   // main digit: decimal point lives in bit 7 of the following byte
   function automatic void put_main_digit(int b, int v);
      logic [7:0] g;
      logic [7:0] x;
      if (v >= 10 && v <= 19) begin
         v = v - 10;
         lcd_image[b + 1] = lcd_image[b + 1] | 8'h80;
      end else begin
         lcd_image[b + 1] = lcd_image[b + 1] & 8'h7F;
      end
      g = glyph_for(v);
      x = lcd_image[b];
      x = (x & 8'h8F) | (g << 4);
      x = (x & 8'hF0) | (g >> 4);
      lcd_image[b] = x;
   endfunction

   // small digit spread over the high nibble of one byte and low nibble of the next
   function automatic void put_split_digit(int b, int v);
      logic [7:0] g;
      g = glyph_for(v);
      lcd_image[b + 1] = (lcd_image[b + 1] & 8'hF0) | (g >> 4);
      lcd_image[b]     = (lcd_image[b] & 8'h0F) | (g << 4);
   endfunction

   function automatic void place_glyph(int slot, int v);
      case (slot)
         0: put_main_digit(1, v);
         1: put_main_digit(2, v);
         2: put_main_digit(3, v);
         3: put_main_digit(4, v);
         4: lcd_image[10] = glyph_for(v);
         5: lcd_image[9] = glyph_for(v);
         6: put_split_digit(7, v);
         7: put_split_digit(6, v);
         default: ;
      endcase
   endfunction

   // queue header plus image bytes of one frame
   function automatic void queue_frame();
      lcd_out_type e;
      e.data = {4'h0, hdr_mode};
      e.hdr  = 1'b1;
      e.lst  = 1'b0;
      e.bl   = backlight_on;
      frame_expect.push_back(e);
      for (int k = 0; k < FRAME_LEN; k++) begin
         e.data = lcd_image[k];
         e.hdr  = 1'b0;
         e.lst  = (k == FRAME_LEN - 1);
         frame_expect.push_back(e);
      end
   endfunction

   function automatic void lcd_apply_item(logic kind, logic [9:0] addr, logic [7:0] value);
      int v;
      int a;
      v = int'($signed(value));
      a = int'(addr);
      if (kind == KIND_FLUSH) begin
         if (image_dirty) begin
            queue_frame();
            image_dirty = 1'b0;
         end
         return;
      end
      if (a < 256) begin
         if (a < int'(slot_base)) begin
            if (v > 0) lcd_image[a >> 3][a & 7] = 1'b1;
            else lcd_image[a >> 3][a & 7] = 1'b0;
         end else begin
            place_glyph(a - int'(slot_base), v);
         end
      end else if (addr == slfd_pkg::ADDR_FILL) begin
         for (int i = 0; i < IMG_SIZE; i++) lcd_image[i] = (v != 0) ? 8'hFF : 8'h00;
         queue_frame();
      end else if (addr == slfd_pkg::ADDR_BACKLIGHT) begin
         backlight_on = value[0];
      end
      image_dirty = 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // result side
   // ------------------------------------------------------------------

   // receiver readiness: per-result stalls and long hold-offs
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_valid && rsp_ready) begin
            rx_stall = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
            rsp_ready <= (rx_stall == 0);
         end else if (rx_stall > 0) begin
            rx_stall--;
            rsp_ready <= (rx_stall == 0);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // compare each result transfer with the oldest queued frame element
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (frame_expect.size() == 0) begin
            $display("%0t: unexpected result, expected none, got byte %02h hdr %0b last %0b",
                     $time, rsp_frame_byte, rsp_is_header, rsp_last);
            error_count++;
         end else begin
            want = frame_expect.pop_front();
            bytes_checked++;
            if (want.hdr) frames_checked++;
            if (rsp_frame_byte !== want.data) begin
               $display("%0t: frame_byte mismatch, expected %02h, got %02h",
                        $time, want.data, rsp_frame_byte);
               error_count++;
            end
            if (rsp_is_header !== want.hdr) begin
               $display("%0t: is_header mismatch, expected %0b, got %0b",
                        $time, want.hdr, rsp_is_header);
               error_count++;
            end
            if (rsp_last !== want.lst) begin
               $display("%0t: last mismatch, expected %0b, got %0b",
                        $time, want.lst, rsp_last);
               error_count++;
            end
            if (rsp_backlight !== want.bl) begin
               $display("%0t: backlight mismatch, expected %0b, got %0b",
                        $time, want.bl, rsp_backlight);
               error_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------

   // one item transfer; valid stays up so back-to-back items need no gap
   task automatic send_item(input logic kind, input logic [9:0] addr, input logic [7:0] value);
      int gap;
      gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_kind    <= kind;
      req_address <= addr;
      req_value   <= value;
      do @(posedge clock); while (!req_ready);
      lcd_apply_item(kind, addr, value);
      items_sent++;
   endtask

   // drop valid and wait for every queued result plus write settling time
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (frame_expect.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      // return the bus to idle between accesses
      @(posedge clock);
   endtask

   task automatic check_register(input logic idx);
      logic [31:0] rd;
      logic [31:0] exp_val;
      exp_val = (idx == slfd_pkg::REG_MODE) ? {28'd0, hdr_mode} : {24'd0, slot_base};
      csr_access(1'b0, {idx, 2'b00}, 32'd0, rd);
      if (rd !== exp_val) begin
         $display("%0t: register %0d readback mismatch, expected %0h, got %0h",
                  $time, idx, exp_val, rd);
         error_count++;
      end
   endtask

   // register write only with the block quiet
   task automatic set_register(input logic idx, input logic [31:0] data);
      logic [31:0] rd;
      wait_idle();
      csr_access(1'b1, {idx, 2'b00}, data, rd);
      if (idx == slfd_pkg::REG_MODE) hdr_mode = data[3:0];
      else slot_base = data[7:0];
      reg_writes++;
      check_register(idx);
   endtask

   task automatic send_random_item();
      int pick;
      int off;
      logic       k;
      logic [9:0] a;
      logic [7:0] v;
      pick = $urandom_range(0, 99);
      k = KIND_WRITE;
      a = 10'($urandom_range(0, 255));
      v = 8'($urandom_range(0, 255));
      if (pick < 30) begin
         // pictogram bit below the digit slots
         if (slot_base > 0) a = 10'($urandom_range(0, int'(slot_base) - 1));
         if ($urandom_range(0, 2) == 0) v = 8'($urandom_range(0, 1));
      end else if (pick < 55) begin
         // digit slot, including the unused slots above the eighth
         off = $urandom_range(0, 10);
         a = (int'(slot_base) + off > 255) ? {2'b00, slot_base}
                                           : 10'(int'(slot_base) + off);
         case ($urandom_range(0, 2))
            0: v = 8'($urandom_range(0, 19));
            1: v = 8'($urandom_range(0, 60));
            default: ;
         endcase
      end else if (pick < 70) begin
         k = KIND_FLUSH;
         a = 10'($urandom_range(0, 1023));
      end else if (pick < 76) begin
         a = slfd_pkg::ADDR_FILL;
         if ($urandom_range(0, 1) == 0) v = 8'h00;
      end else if (pick < 82) begin
         a = slfd_pkg::ADDR_BACKLIGHT;
      end else if (pick < 88) begin
         a = 10'($urandom_range(256, 1023));
      end else begin
         k = 1'($urandom_range(0, 1));
         a = 10'($urandom_range(0, 1023));
      end
      send_item(k, a, v);
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // reset values, clean flush, first fill frame
   task automatic test_reset_state();
      check_register(slfd_pkg::REG_MODE);
      check_register(slfd_pkg::REG_BASE);
      send_item(KIND_FLUSH, 10'd0, 8'h00);
      send_item(KIND_WRITE, slfd_pkg::ADDR_FILL, 8'h00);
   endtask

   // set and clear single pictogram bits, zero and negative clear
   task automatic test_pictograms();
      send_item(KIND_WRITE, 10'd0, 8'h01);
      send_item(KIND_WRITE, 10'd7, 8'h7F);
      send_item(KIND_WRITE, 10'd200, 8'h01);
      send_item(KIND_WRITE, 10'd244, 8'h05);
      send_item(KIND_WRITE, 10'd0, 8'h00);
      send_item(KIND_WRITE, 10'd7, 8'h80);
      send_item(KIND_FLUSH, 10'd0, 8'h00);
   endtask

   // all eight slots, decimal point, blank glyphs, slots past the last
   task automatic test_digit_slots();
      send_item(KIND_WRITE, 10'd245, 8'd19);
      send_item(KIND_WRITE, 10'd246, 8'd10);
      send_item(KIND_WRITE, 10'd247, 8'd9);
      send_item(KIND_WRITE, 10'd248, 8'd50);
      send_item(KIND_WRITE, 10'd249, 8'd51);
      send_item(KIND_WRITE, 10'd250, 8'hFB);
      send_item(KIND_WRITE, 10'd251, 8'd7);
      send_item(KIND_WRITE, 10'd252, 8'd127);
      send_item(KIND_WRITE, 10'd253, 8'd3);
      send_item(KIND_WRITE, 10'd255, 8'd8);
      send_item(KIND_FLUSH, 10'd0, 8'h00);
      send_item(KIND_WRITE, 10'd245, 8'd4);
      send_item(KIND_FLUSH, 10'd1023, 8'hFF);
   endtask

   // fills, backlight, unused addresses, flush after fill
   task automatic test_fill_and_backlight();
      send_item(KIND_WRITE, slfd_pkg::ADDR_BACKLIGHT, 8'h01);
      send_item(KIND_WRITE, slfd_pkg::ADDR_FILL, 8'hFF);
      send_item(KIND_FLUSH, 10'd0, 8'h00);
      send_item(KIND_WRITE, 10'd256, 8'h05);
      send_item(KIND_WRITE, 10'd1023, 8'h01);
      send_item(KIND_FLUSH, 10'd1023, 8'h7F);
      send_item(KIND_WRITE, slfd_pkg::ADDR_BACKLIGHT, 8'h02);
      send_item(KIND_WRITE, slfd_pkg::ADDR_FILL, 8'h00);
   endtask

   // lowest and highest register settings
   task automatic test_register_extremes();
      set_register(slfd_pkg::REG_MODE, 32'd0);
      set_register(slfd_pkg::REG_BASE, 32'd0);
      send_item(KIND_WRITE, 10'd0, 8'd3);
      send_item(KIND_WRITE, 10'd7, 8'd15);
      send_item(KIND_WRITE, 10'd8, 8'd1);
      send_item(KIND_WRITE, 10'd255, 8'd1);
      send_item(KIND_FLUSH, 10'd0, 8'h00);
      set_register(slfd_pkg::REG_MODE, 32'd15);
      set_register(slfd_pkg::REG_BASE, 32'd255);
      send_item(KIND_WRITE, 10'd254, 8'd1);
      send_item(KIND_WRITE, 10'd255, 8'd12);
      send_item(KIND_FLUSH, 10'd0, 8'h00);
   endtask

   // receiver holds off while frames pile up, then the sender waits for the drain
   task automatic test_backpressure();
      wait_idle();
      gaps_on = 1'b0;
      hold_left = HOLD_CYCLES;
      send_item(KIND_WRITE, slfd_pkg::ADDR_FILL, 8'h01);
      send_item(KIND_WRITE, 10'd3, 8'h00);
      send_item(KIND_FLUSH, 10'd0, 8'h00);
      send_item(KIND_WRITE, slfd_pkg::ADDR_FILL, 8'h00);
      send_item(KIND_WRITE, slfd_pkg::ADDR_BACKLIGHT, 8'h01);
      send_item(KIND_FLUSH, 10'd0, 8'h00);
      send_item(KIND_WRITE, slfd_pkg::ADDR_FILL, 8'h22);
      send_item(KIND_WRITE, 10'd100, 8'h01);
      send_item(KIND_FLUSH, 10'd0, 8'h00);
      wait_idle();
      gaps_on = 1'b1;
   endtask

   // random traffic under a fresh random register setting
   task automatic test_random_traffic(input int count, input bit with_gaps);
      set_register(slfd_pkg::REG_MODE, $urandom_range(0, 15));
      if ($urandom_range(0, 1) == 0) set_register(slfd_pkg::REG_BASE, $urandom_range(236, 255));
      else set_register(slfd_pkg::REG_BASE, $urandom_range(0, 255));
      gaps_on = with_gaps;
      repeat (count) send_random_item();
      gaps_on = 1'b1;
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      lcd_clear_state();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_pictograms();
      test_digit_slots();
      test_fill_and_backlight();
      test_register_extremes();
      test_backpressure();
      test_random_traffic(65, 1'b1);
      test_random_traffic(65, 1'b0);
      test_random_traffic(65, 1'b1);
      test_random_traffic(65, 1'b1);

      wait_idle();
      repeat (60) @(posedge clock);

      $display("covered %0d items, %0d frames (%0d bytes) checked, %0d register writes",
               items_sent, frames_checked, bytes_checked, reg_writes);
      $display("pictograms, digit slots, fills, backlight, flushes, stalls and hold-off");
      if (error_count == 0) begin
         $display("** segment_lcd_frame_driver_unit: PASSED **");
      end else begin
         $display("%0d mismatches", error_count);
         $display("** segment_lcd_frame_driver_unit: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire
